// ===== rtl/ftma_pkg.sv =====
// Shared types, codes and constants of the frame timer with moving average.
package ftma_pkg;

  localparam int STAMP_W  = 48;
  localparam int SAMPLE_W = 32;
  localparam int RATE_W   = 16;
  localparam int CFG_W    = 32;
  localparam int IDX_W    = 2;
  localparam int ACCUM_W  = 33;

  localparam logic [IDX_W-1:0] REG_MIN_INTERVAL  = 2'd0;
  localparam logic [IDX_W-1:0] REG_SECOND_LENGTH = 2'd1;
  localparam logic [IDX_W-1:0] REG_OUTLIER_LIMIT = 2'd2;

  localparam logic [CFG_W-1:0] MIN_INTERVAL_RST  = 32'd16667;
  localparam logic [CFG_W-1:0] SECOND_LENGTH_RST = 32'd1000000;
  localparam logic [CFG_W-1:0] OUTLIER_LIMIT_RST = 32'd1000000;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_START = 2'd2,
    CMD_RESET = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF,
    S_RESUME,
    S_MINCHK,
    S_OUTCHK,
    S_STORE,
    S_ADD,
    S_DIVINIT,
    S_DIV,
    S_TOTAL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic latch_in;
    logic tick_run;
    logic avg_clear;
    logic do_stop;
    logic do_resume;
    logic do_reset;
    logic take_frame;
    logic count_frame;
    logic store_sample;
    logic add_sample;
    logic div_start;
    logic div_finish;
    logic calc_total;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic stopped;
    logic below_min;
    logic keep_sample;
    logic count_zero;
    logic div_done;
  } dp_stat_t;

endpackage

// ===== rtl/ftma_if.sv =====
// Channel interfaces of the frame timer: input words, result words and register writes.
interface ftma_in_if;
  import ftma_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [STAMP_W-1:0] now_time;
  modport source (output valid, cmd, now_time, input ready);
  modport sink (input valid, cmd, now_time, output ready);
endinterface

interface ftma_out_if;
  import ftma_pkg::*;
  logic                valid;
  logic                ready;
  logic                frame_taken;
  logic [SAMPLE_W-1:0] avg_frame_time;
  logic [RATE_W-1:0]   frame_rate;
  logic [STAMP_W-1:0]  total_time;
  modport source (output valid, frame_taken, avg_frame_time, frame_rate, total_time,
                  input ready);
  modport sink (input valid, frame_taken, avg_frame_time, frame_rate, total_time,
                output ready);
endinterface

interface ftma_cfg_if;
  import ftma_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [CFG_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/ftma_ram.sv =====
// Generic single-port-write, registered-read RAM.
module ftma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/ftma_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
module ftma_div #(
  parameter int NUM_W = 38,
  parameter int DEN_W = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [DEN_W-1:0]  rem_r;
  logic [DEN_W-1:0]  den_r;
  logic [NUM_W-1:0]  quo_r;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    trial_sub;
  logic              fits;

  assign trial     = {rem_r, quo_r[NUM_W-1]};
  assign trial_sub = trial - {1'b0, den_r};
  assign fits      = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(NUM_W);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // The partial remainder always stays below the divisor, so it fits in DEN_W bits.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

// ===== rtl/ftma_dp.sv =====
// Datapath of the frame timer: registers, stamps, sample window, sums and divider.
module ftma_dp #(
  parameter int WINDOW_DEPTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ftma_pkg::ctrl_cmd_t          cmd,
  output ftma_pkg::dp_stat_t           stat,
  input  logic [1:0]                   in_cmd,
  input  logic [ftma_pkg::STAMP_W-1:0] in_now,
  input  logic                         cfg_valid,
  input  logic [ftma_pkg::IDX_W-1:0]   cfg_index,
  input  logic [ftma_pkg::CFG_W-1:0]   cfg_data,
  output logic                         out_taken,
  output logic [ftma_pkg::SAMPLE_W-1:0] out_avg,
  output logic [ftma_pkg::RATE_W-1:0]  out_rate,
  output logic [ftma_pkg::STAMP_W-1:0] out_total
);
  import ftma_pkg::*;

  localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W = SAMPLE_W + CNT_W;

  logic [CFG_W-1:0]    min_int_r;
  logic [CFG_W-1:0]    sec_len_r;
  logic [CFG_W-1:0]    outlier_r;
  cmd_t                cmd_r;
  logic [STAMP_W-1:0]  now_r;
  logic [STAMP_W-1:0]  diff_r;
  logic [STAMP_W-1:0]  dev_r;
  logic [STAMP_W-1:0]  tot_r;
  logic                taken_r;
  logic                stopped_r;
  logic [STAMP_W-1:0]  start_r;
  logic [STAMP_W-1:0]  stop_r;
  logic [STAMP_W-1:0]  pause_r;
  logic [STAMP_W-1:0]  cur_r;
  logic [STAMP_W-1:0]  last_r;
  logic [PTR_W-1:0]    ptr_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [SUM_W-1:0]    sum_r;
  logic [SAMPLE_W-1:0] avg_r;
  logic [RATE_W-1:0]   frames_r;
  logic [ACCUM_W-1:0]  accum_r;
  logic [RATE_W-1:0]   rate_r;
  logic                out_taken_r;
  logic [SAMPLE_W-1:0] out_avg_r;
  logic [RATE_W-1:0]   out_rate_r;
  logic [STAMP_W-1:0]  out_total_r;

  logic [STAMP_W-1:0]  diff_src;
  logic [STAMP_W-1:0]  diff_calc;
  logic [STAMP_W-1:0]  avg_ext;
  logic [STAMP_W-1:0]  dev_calc;
  logic [SAMPLE_W-1:0] sample;
  logic [ACCUM_W-1:0]  accum_sum;
  logic                accum_over;
  logic [RATE_W-1:0]   frames_inc;
  logic                full;
  logic [PTR_W-1:0]    ptr_next;
  logic [STAMP_W-1:0]  endp;
  logic [SAMPLE_W-1:0] old_sample;
  logic                div_done;
  logic [SUM_W-1:0]    div_quot;

  // A start measures the paused span, everything else the span since the last frame.
  assign diff_src   = (cmd_r == CMD_START) ? stop_r : last_r;
  assign diff_calc  = now_r - diff_src;
  assign avg_ext    = {{(STAMP_W-SAMPLE_W){1'b0}}, avg_r};
  assign dev_calc   = (diff_r >= avg_ext) ? (diff_r - avg_ext) : (avg_ext - diff_r);
  assign sample     = (|diff_r[STAMP_W-1:SAMPLE_W]) ? '1 : diff_r[SAMPLE_W-1:0];
  assign accum_sum  = accum_r + {1'b0, diff_r[SAMPLE_W-1:0]};
  assign accum_over = (|diff_r[STAMP_W-1:SAMPLE_W]) || (accum_sum > {1'b0, sec_len_r});
  assign frames_inc = (frames_r == '1) ? frames_r : (frames_r + 1'b1);
  assign full       = (cnt_r == CNT_W'(WINDOW_DEPTH));
  assign ptr_next   = (ptr_r == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : (ptr_r + 1'b1);
  assign endp       = stopped_r ? stop_r : cur_r;

  ftma_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW_DEPTH),
    .AW    (PTR_W)
  ) u_window (
    .clk   (clk),
    .we    (cmd.store_sample),
    .waddr (ptr_r),
    .wdata (sample),
    .raddr (ptr_r),
    .rdata (old_sample)
  );

  ftma_div #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (sum_r),
    .den   (cnt_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_int_r <= MIN_INTERVAL_RST;
      sec_len_r <= SECOND_LENGTH_RST;
      outlier_r <= OUTLIER_LIMIT_RST;
      cmd_r     <= CMD_TICK;
      stopped_r <= 1'b0;
      start_r   <= '0;
      stop_r    <= '0;
      pause_r   <= '0;
      cur_r     <= '0;
      last_r    <= '0;
      ptr_r     <= '0;
      cnt_r     <= '0;
      sum_r     <= '0;
      avg_r     <= '0;
      frames_r  <= '0;
      accum_r   <= '0;
      rate_r    <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_MIN_INTERVAL:  min_int_r <= cfg_data;
          REG_SECOND_LENGTH: sec_len_r <= cfg_data;
          REG_OUTLIER_LIMIT: outlier_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.latch_in) begin
        cmd_r <= cmd_t'(in_cmd);
      end
      if (cmd.tick_run) begin
        cur_r <= now_r;
      end
      if (cmd.avg_clear) begin
        avg_r <= '0;
      end
      if (cmd.do_stop) begin
        stop_r    <= now_r;
        stopped_r <= 1'b1;
      end
      if (cmd.do_resume) begin
        last_r    <= now_r;
        pause_r   <= pause_r + diff_r;
        stop_r    <= '0;
        stopped_r <= 1'b0;
      end
      if (cmd.do_reset) begin
        start_r   <= now_r;
        last_r    <= now_r;
        stop_r    <= '0;
        stopped_r <= 1'b0;
        pause_r   <= '0;
      end
      if (cmd.take_frame) begin
        last_r <= now_r;
      end
      if (cmd.count_frame) begin
        if (accum_over) begin
          rate_r   <= frames_inc;
          frames_r <= '0;
          accum_r  <= '0;
        end else begin
          frames_r <= frames_inc;
          accum_r  <= accum_sum;
        end
      end
      // Once the window is full the oldest sample sits at the write pointer.
      if (cmd.store_sample) begin
        if (full) begin
          sum_r <= sum_r - {{(SUM_W-SAMPLE_W){1'b0}}, old_sample};
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
        ptr_r <= ptr_next;
      end
      if (cmd.add_sample) begin
        sum_r <= sum_r + {{(SUM_W-SAMPLE_W){1'b0}}, sample};
      end
      if (cmd.div_finish) begin
        avg_r <= div_quot[SAMPLE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      now_r   <= in_now;
      taken_r <= 1'b0;
      diff_r  <= '0;
    end else if (cmd_r == CMD_TICK || cmd_r == CMD_START) begin
      diff_r <= (cmd.do_resume || cmd.take_frame || cmd.count_frame || cmd.store_sample
                 || cmd.add_sample) ? diff_r : diff_calc;
    end
    if (cmd.take_frame) begin
      taken_r <= 1'b1;
      dev_r   <= dev_calc;
    end
    if (cmd.calc_total) begin
      tot_r <= endp - pause_r;
    end
    if (cmd.load_out) begin
      out_taken_r <= taken_r;
      out_avg_r   <= avg_r;
      out_rate_r  <= rate_r;
      out_total_r <= tot_r - start_r;
    end
  end

  assign stat.cmd         = cmd_r;
  assign stat.stopped     = stopped_r;
  assign stat.below_min   = diff_r < {{(STAMP_W-CFG_W){1'b0}}, min_int_r};
  assign stat.keep_sample = dev_r < {{(STAMP_W-CFG_W){1'b0}}, outlier_r};
  assign stat.count_zero  = (cnt_r == '0);
  assign stat.div_done    = div_done;

  assign out_taken = out_taken_r;
  assign out_avg   = out_avg_r;
  assign out_rate  = out_rate_r;
  assign out_total = out_total_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(WINDOW_DEPTH))
    else $error("sample count beyond window depth");

  a_ptr_tracks_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    !full |-> (CNT_W'(ptr_r) == cnt_r))
    else $error("write pointer out of step with sample count");

  a_frame_running: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take_frame |-> !stopped_r)
    else $error("frame taken while stopped");
`endif

endmodule

// ===== rtl/ftma_ctrl.sv =====
// Controller state machine of the frame timer.
module ftma_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  ftma_pkg::dp_stat_t  stat,
  output ftma_pkg::ctrl_cmd_t cmd
);
  import ftma_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_DIFF;
        end
      end
      S_DIFF: begin
        unique case (stat.cmd)
          CMD_TICK: begin
            if (stat.stopped) begin
              cmd.avg_clear = 1'b1;
              state_nxt     = S_TOTAL;
            end else begin
              cmd.tick_run = 1'b1;
              state_nxt    = S_MINCHK;
            end
          end
          CMD_STOP: begin
            cmd.do_stop = !stat.stopped;
            state_nxt   = S_TOTAL;
          end
          CMD_START: begin
            state_nxt = stat.stopped ? S_RESUME : S_TOTAL;
          end
          CMD_RESET: begin
            cmd.do_reset = 1'b1;
            state_nxt    = S_TOTAL;
          end
        endcase
      end
      S_RESUME: begin
        cmd.do_resume = 1'b1;
        state_nxt     = S_TOTAL;
      end
      S_MINCHK: begin
        if (stat.below_min) begin
          state_nxt = S_TOTAL;
        end else begin
          cmd.take_frame = 1'b1;
          state_nxt      = S_OUTCHK;
        end
      end
      S_OUTCHK: begin
        cmd.count_frame = 1'b1;
        state_nxt       = stat.keep_sample ? S_STORE : S_DIVINIT;
      end
      S_STORE: begin
        cmd.store_sample = 1'b1;
        state_nxt        = S_ADD;
      end
      S_ADD: begin
        cmd.add_sample = 1'b1;
        state_nxt      = S_DIVINIT;
      end
      S_DIVINIT: begin
        if (stat.count_zero) begin
          cmd.avg_clear = 1'b1;
          state_nxt     = S_TOTAL;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.div_finish = 1'b1;
          state_nxt      = S_TOTAL;
        end
      end
      S_TOTAL: begin
        cmd.calc_total = 1'b1;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        // The result register takes the new word once the previous one has gone.
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !stat.count_zero)
    else $error("divider started with an empty window");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("pending result word overwritten");

  a_minchk_running: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MINCHK) |-> !stat.stopped)
    else $error("interval check reached while stopped");
`endif

endmodule

// ===== rtl/frame_timer_moving_average.sv =====
// Top level of the frame timer with moving-average frame interval.
// Stop, start, reset and rejected ticks skip the window and the divider and go on to the total and
// the result word. An accepted frame runs the outlier check, stores its sample when it is kept,
// and waits on the serial window-mean divider unless the window is empty.
// One word is in work at a time; the next is accepted the cycle after the result register loads.
// Synchronous active-low reset restores register defaults; the window needs no clearing.
module frame_timer_moving_average #(
  parameter int WINDOW_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  ftma_in_if.sink    in_chan,
  ftma_out_if.source out_chan,
  ftma_cfg_if.sink   cfg_chan
);
  import ftma_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  logic      in_ready;
  logic      out_valid;

  ftma_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ftma_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_cmd    (in_chan.cmd),
    .in_now    (in_chan.now_time),
    .cfg_valid (cfg_chan.valid),
    .cfg_index (cfg_chan.index),
    .cfg_data  (cfg_chan.data),
    .out_taken (out_chan.frame_taken),
    .out_avg   (out_chan.avg_frame_time),
    .out_rate  (out_chan.frame_rate),
    .out_total (out_chan.total_time)
  );

  assign in_chan.ready  = in_ready;
  assign out_chan.valid = out_valid;
  assign cfg_chan.ready = 1'b1;

endmodule
